// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, ck, rs, prop)
`define ASSERT_NEVER(lbl, ck, rs, cond)
`endif
`endif

// ===== hw/rtl/lru_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lru_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // One key/value pair as held in a cell and handed down the chain.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level: fully associative LRU key/value cache built as a chain of recency cells.
// The result strobe (done) is registered from the update state, which follows the compare state.
// A new transaction is accepted only in the idle state; busy covers the compare and update states.
// The compare state checks the key in every cell; the update state shifts the chain and writes the front.
// Synchronous active-high rst empties the cache and sets capacity to min(16, ENTRIES).
// The receiver cannot stall: done is high for one cycle only; hit and read_value hold until the next result.
`include "assert_macros.svh"
module lru_key_value_cache
  import lru_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    operation,
  input  logic signed [KEY_W-1:0] lookup_key,
  input  logic signed [VAL_W-1:0] write_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        capacity_in_use,
  output logic                    done,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value
);

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMPW = ((CW > CAP_W) ? CW : CAP_W) + 1;
  localparam int CAP_RST = (ENTRIES < CAP_RESET) ? ENTRIES : CAP_RESET;

  state_t            state, state_next;
  logic [CAP_W-1:0]  cap;
  logic [CW-1:0]     count;
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;

  // registered decisions from the compare cycle
  logic              hit_r;
  logic [VAL_W-1:0]  hit_val_r;
  logic              load_any_r;
  logic [IW-1:0]     lim_r;
  logic              grow_r;

  entry_t            cells   [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] load;
  entry_t            front;

  logic              hit_c;
  logic [IW-1:0]     pos_c;
  logic [VAL_W-1:0]  hit_val_c;
  logic              evict_c;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_W'(CAP_RST);
    end else if (cfg_valid && cfg_ready) begin
      if (int'(capacity_in_use) > ENTRIES) begin
        cap <= CAP_W'(ENTRIES);
      end else begin
        cap <= capacity_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= operation;
      key_r <= lookup_key;
      val_r <= write_value;
    end
  end

  // Front of the chain: the entry that becomes most recent.
  always_comb begin
    front.valid = 1'b1;
    front.key   = key_r;
    front.value = (op_r == OP_PUT) ? val_r : hit_val_r;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign load[i] = (state == ST_UPDATE) && load_any_r && (IW'(i) <= lim_r);
    assign valid_vec[i] = cells[i].valid;
    if (i == 0) begin : g_head
      lru_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .load       (load[i]),
        .prev_entry (front),
        .cmp_key    (key_r),
        .entry      (cells[i]),
        .match      (match[i])
      );
    end else begin : g_body
      lru_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .load       (load[i]),
        .prev_entry (cells[i-1]),
        .cmp_key    (key_r),
        .entry      (cells[i]),
        .match      (match[i])
      );
    end
  end

  // At most one cell matches, so the encode and the value gather are plain ORs.
  always_comb begin
    hit_c     = |match;
    pos_c     = '0;
    hit_val_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        pos_c     = pos_c | IW'(i);
        hit_val_c = hit_val_c | cells[i].value;
      end
    end
    evict_c = ((CMPW'(count) + CMPW'(1)) > CMPW'(cap)) || (count == CW'(ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      hit_r     <= hit_c;
      hit_val_r <= hit_val_c;
      if (hit_c) begin
        load_any_r <= 1'b1;
        lim_r      <= pos_c;
        grow_r     <= 1'b0;
      end else if (op_r == OP_PUT) begin
        // new key: shift the occupied run down, dropping the LRU entry on eviction
        load_any_r <= !(evict_c && (count == '0));
        lim_r      <= evict_c ? IW'(count - CW'(1)) : IW'(count);
        grow_r     <= !evict_c;
      end else begin
        load_any_r <= 1'b0;
        lim_r      <= '0;
        grow_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if ((state == ST_UPDATE) && grow_r) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit <= hit_r;
      if (op_r == OP_PUT) begin
        read_value <= '0;
      end else if (hit_r) begin
        read_value <= hit_val_r;
      end else begin
        read_value <= '1;
      end
    end
  end

  `ASSERT_CLK(a_match_unique, clk, rst, $onehot0(match))
  `ASSERT_CLK(a_valid_matches_count, clk, rst, $countones(valid_vec) == int'(count))
  `ASSERT_CLK(a_done_after_update, clk, rst, done |-> $past(state == ST_UPDATE))
  `ASSERT_NEVER(a_count_bound, clk, rst, int'(count) > ENTRIES)

endmodule

// ===== hw/rtl/lru_cell.sv =====
// One recency slot: holds an entry, compares it with the key, loads from its neighbour.
module lru_cell
  import lru_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  entry_t           prev_entry,
  input  logic [KEY_W-1:0] cmp_key,
  output entry_t           entry,
  output logic             match
);

  always_ff @(posedge clk) begin
    if (load) begin
      entry.key   <= prev_entry.key;
      entry.value <= prev_entry.value;
    end
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (load) begin
      entry.valid <= prev_entry.valid;
    end
  end

  assign match = entry.valid && (entry.key == cmp_key);

endmodule
